/* rtl/core/mrhs_pkg.sv */
// Shared types, codes and helpers of the run/hold supervisor.
`timescale 1ns / 1ps

package mrhs_pkg;

  // Event codes carried in the command field
  localparam logic [3:0] CMD_TICK       = 4'd0;
  localparam logic [3:0] CMD_SEEK_HOLD  = 4'd1;
  localparam logic [3:0] CMD_HOLDING    = 4'd2;
  localparam logic [3:0] CMD_RUNNING    = 4'd3;
  localparam logic [3:0] CMD_JOGGING    = 4'd4;
  localparam logic [3:0] CMD_IDLE       = 4'd5;
  localparam logic [3:0] CMD_ESTOP      = 4'd6;
  localparam logic [3:0] CMD_PAUSE_REQ  = 4'd7;
  localparam logic [3:0] CMD_PAUSE_EXEC = 4'd8;
  localparam logic [3:0] CMD_STOP       = 4'd9;
  localparam logic [3:0] CMD_UNPAUSE    = 4'd10;
  localparam logic [3:0] CMD_RESUME     = 4'd11;
  localparam logic [3:0] CMD_FLUSH      = 4'd12;

  // Pause kinds
  localparam logic [1:0] PK_USER     = 2'd0;
  localparam logic [1:0] PK_PROGRAM  = 2'd1;
  localparam logic [1:0] PK_OPTIONAL = 2'd2;

  // Hold reasons
  localparam logic [2:0] RS_USER_PAUSE = 3'd0;
  localparam logic [2:0] RS_USER_STOP  = 3'd1;
  localparam logic [2:0] RS_PROG_PAUSE = 3'd2;
  localparam logic [2:0] RS_OPT_PAUSE  = 3'd3;
  localparam logic [2:0] RS_FOUND      = 3'd4;
  localparam logic [2:0] RS_NOT_FOUND  = 3'd5;

  // Reported machine state codes
  localparam logic [2:0] MS_READY    = 3'd0;
  localparam logic [2:0] MS_ESTOPPED = 3'd1;
  localparam logic [2:0] MS_RUNNING  = 3'd2;
  localparam logic [2:0] MS_JOGGING  = 3'd3;
  localparam logic [2:0] MS_STOPPING = 3'd4;
  localparam logic [2:0] MS_HOLDING  = 3'd5;

  // Internal one-hot machine state
  typedef enum logic [5:0] {
    ST_READY    = 6'b000001,
    ST_ESTOPPED = 6'b000010,
    ST_RUNNING  = 6'b000100,
    ST_JOGGING  = 6'b001000,
    ST_STOPPING = 6'b010000,
    ST_HOLDING  = 6'b100000
  } state_t;

  typedef struct packed {
    logic [3:0] command;
    logic       switch_found;
    logic [1:0] pause_kind;
    logic       estop_active;
    logic       motion_busy;
    logic       queue_nonempty;
  } item_t;

  typedef struct packed {
    logic [2:0]  machine_state;
    logic [15:0] change_count;
    logic [2:0]  reason;
    logic        flushing_now;
    logic        resuming_now;
    logic        flush_pulse;
    logic        halt_outputs_pulse;
    logic        push_pause_pulse;
    logic [1:0]  pushed_kind;
  } result_t;

  // Map the one-hot state to its reported code
  function automatic logic [2:0] state_code(input state_t s);
    logic [2:0] code;
    case (s)
      ST_READY:    code = MS_READY;
      ST_ESTOPPED: code = MS_ESTOPPED;
      ST_RUNNING:  code = MS_RUNNING;
      ST_JOGGING:  code = MS_JOGGING;
      ST_STOPPING: code = MS_STOPPING;
      ST_HOLDING:  code = MS_HOLDING;
      default:     code = MS_READY;
    endcase
    return code;
  endfunction

endpackage

/* rtl/core/machine_run_hold_supervisor.sv */
// An accepted item's result passes the input register, then the result register, where
// it waits to be taken. Throughput: one item per cycle unless the result stalls;
// the state update is a single pass of logic per item.
// While a result waits to be taken, the input register takes one more item, then stalls.
// Reset (rst, synchronous): state ready, counter and reason zero, flush flag set,
// all request flags cleared, both registers empty.
`timescale 1ns / 1ps

module machine_run_hold_supervisor (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  mrhs_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output mrhs_pkg::result_t result
);
  import mrhs_pkg::*;

  logic    held_valid;
  logic    advance;
  item_t   held;
  result_t result_next;

  // Input register
  mrhs_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .advance    (advance),
    .held_valid (held_valid),
    .held       (held)
  );

  // State and update logic
  mrhs_core u_core (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .held        (held),
    .result_next (result_next)
  );

  // Result register
  mrhs_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .held_valid   (held_valid),
    .advance      (advance),
    .result_next  (result_next),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

/* rtl/core/mrhs_in_stage.sv */
// Input register of the supervisor: holds one accepted item.
`timescale 1ns / 1ps

module mrhs_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  input  mrhs_pkg::item_t item,
  input  logic           advance,
  output logic           held_valid,
  output mrhs_pkg::item_t held
);
  import mrhs_pkg::*;

  // Take a new item when empty or when the held one moves on
  assign item_stall = held_valid & ~advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!item_stall) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      held <= item;
    end
  end

endmodule

/* rtl/core/mrhs_core.sv */
// Supervisor state registers and the per-item update logic.
`timescale 1ns / 1ps

module mrhs_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  mrhs_pkg::item_t   held,
  output mrhs_pkg::result_t result_next
);
  import mrhs_pkg::*;

  state_t      state, state_next;
  logic [15:0] count, count_next;
  logic [2:0]  cause, cause_next;
  logic        flush_flag, flush_flag_next;
  logic        resume_flag, resume_flag_next;
  logic        stop_pend, stop_pend_next;
  logic        pause_pend, pause_pend_next;
  logic        unpause_pend, unpause_pend_next;
  logic        flush_p, halt_p, push_p;
  logic [1:0]  pushed;

  // A change is allowed when it moves the state and the state is not estopped
  function automatic logic may_go(input state_t cur, input state_t nxt);
    return (cur != nxt) && (cur != ST_ESTOPPED);
  endfunction

  // Apply one event in the order of its steps
  always_comb begin
    state_next        = state;
    count_next        = count;
    cause_next        = cause;
    flush_flag_next   = flush_flag;
    resume_flag_next  = resume_flag;
    stop_pend_next    = stop_pend;
    pause_pend_next   = pause_pend;
    unpause_pend_next = unpause_pend;
    flush_p           = 1'b0;
    halt_p            = 1'b0;
    push_p            = 1'b0;
    pushed            = 2'd0;

    case (held.command)
      CMD_TICK: begin
        if (!held.estop_active) begin
          // Serve a pending pause
          if (pause_pend) begin
            if (state_next == ST_RUNNING) begin
              cause_next = RS_USER_PAUSE;
              state_next = ST_STOPPING;
              count_next = count_next + 16'd1;
            end
            pause_pend_next = 1'b0;
          end
          // Serve a pending stop
          if (stop_pend) begin
            cause_next = RS_USER_STOP;
            if (state_next == ST_RUNNING) begin
              state_next = ST_STOPPING;
              count_next = count_next + 16'd1;
            end else if (state_next == ST_JOGGING || state_next == ST_READY ||
                         state_next == ST_HOLDING) begin
              halt_p = 1'b1;
            end
            stop_pend_next = 1'b0;
          end
          // Flush while idle; a set resume ends the flush
          if (flush_flag && (state_next == ST_READY || state_next == ST_HOLDING) &&
              !held.motion_busy) begin
            flush_p = 1'b1;
            if (resume_flag) begin
              flush_flag_next  = 1'b0;
              resume_flag_next = 1'b0;
            end
          end
          // Serve a pending unpause
          if (unpause_pend && !flush_flag_next && state_next != ST_STOPPING) begin
            unpause_pend_next = 1'b0;
            if (state_next == ST_HOLDING) begin
              state_next = held.queue_nonempty ? ST_RUNNING : ST_READY;
              count_next = count_next + 16'd1;
            end
          end
        end
      end
      CMD_SEEK_HOLD: begin
        cause_next = held.switch_found ? RS_FOUND : RS_NOT_FOUND;
        if (state == ST_RUNNING) begin
          state_next = ST_STOPPING;
          count_next = count + 16'd1;
        end
      end
      CMD_HOLDING: begin
        if (may_go(state, ST_HOLDING)) begin
          state_next = ST_HOLDING;
          count_next = count + 16'd1;
        end
        // A user stop reason repeats the stop action from holding
        if (cause == RS_USER_STOP && state_next == ST_HOLDING) begin
          halt_p = 1'b1;
        end
      end
      CMD_RUNNING: begin
        if (state == ST_READY) begin
          state_next = ST_RUNNING;
          count_next = count + 16'd1;
        end
      end
      CMD_JOGGING: begin
        if (state == ST_READY || state == ST_HOLDING) begin
          state_next = ST_JOGGING;
          count_next = count + 16'd1;
        end
      end
      CMD_IDLE: begin
        if (state == ST_RUNNING || state == ST_JOGGING) begin
          state_next = ST_READY;
          count_next = count + 16'd1;
        end
      end
      CMD_ESTOP: begin
        if (may_go(state, ST_ESTOPPED)) begin
          state_next = ST_ESTOPPED;
          count_next = count + 16'd1;
        end
      end
      CMD_PAUSE_REQ: begin
        if (held.pause_kind == PK_USER) begin
          pause_pend_next = 1'b1;
        end else begin
          push_p = 1'b1;
          pushed = held.pause_kind;
        end
      end
      CMD_PAUSE_EXEC: begin
        if (held.pause_kind == PK_OPTIONAL || held.pause_kind == PK_PROGRAM) begin
          cause_next = (held.pause_kind == PK_OPTIONAL) ? RS_OPT_PAUSE : RS_PROG_PAUSE;
          if (may_go(state, ST_HOLDING)) begin
            state_next = ST_HOLDING;
            count_next = count + 16'd1;
          end
        end
      end
      CMD_STOP: begin
        stop_pend_next = 1'b1;
      end
      CMD_UNPAUSE: begin
        unpause_pend_next = 1'b1;
      end
      CMD_RESUME: begin
        if (flush_flag) begin
          resume_flag_next = 1'b1;
        end
      end
      CMD_FLUSH: begin
        flush_flag_next = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Status after the event plus this event's pulses
  always_comb begin
    result_next.machine_state      = state_code(state_next);
    result_next.change_count       = count_next;
    result_next.reason             = cause_next;
    result_next.flushing_now       = flush_flag_next & ~resume_flag_next;
    result_next.resuming_now       = resume_flag_next;
    result_next.flush_pulse        = flush_p;
    result_next.halt_outputs_pulse = halt_p;
    result_next.push_pause_pulse   = push_p;
    result_next.pushed_kind        = pushed;
  end

  // Commit the update when the item moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_READY;
      count        <= 16'd0;
      cause        <= RS_USER_PAUSE;
      flush_flag   <= 1'b1;
      resume_flag  <= 1'b0;
      stop_pend    <= 1'b0;
      pause_pend   <= 1'b0;
      unpause_pend <= 1'b0;
    end else if (advance) begin
      state        <= state_next;
      count        <= count_next;
      cause        <= cause_next;
      flush_flag   <= flush_flag_next;
      resume_flag  <= resume_flag_next;
      stop_pend    <= stop_pend_next;
      pause_pend   <= pause_pend_next;
      unpause_pend <= unpause_pend_next;
    end
  end

endmodule

/* rtl/core/mrhs_out_stage.sv */
// Result register of the supervisor with its valid/stall handshake.
`timescale 1ns / 1ps

module mrhs_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              held_valid,
  output logic              advance,
  input  mrhs_pkg::result_t result_next,
  output logic              result_valid,
  input  logic              result_stall,
  output mrhs_pkg::result_t result
);
  import mrhs_pkg::*;

  // Move an item in when the register is empty or being drained
  assign advance = held_valid & (~result_valid | ~result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (!result_valid || !result_stall) begin
      result_valid <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

endmodule

/* rtl/core/mrhs_checker.sv */
// Port checker for the supervisor and its bind to the top level.
`timescale 1ns / 1ps

module mrhs_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_stall,
  input mrhs_pkg::item_t   item,
  input logic              result_valid,
  input logic              result_stall,
  input mrhs_pkg::result_t result
);
  import mrhs_pkg::*;

  logic seen_estop;

  // Remember a delivered estopped result
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_estop <= 1'b0;
    end else if (result_valid && !result_stall &&
                 result.machine_state == MS_ESTOPPED) begin
      seen_estop <= 1'b1;
    end
  end

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // A stalled result stays put
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // Estop is sticky
  a_estop_sticky: assert property (@(posedge clk) disable iff (rst)
    result_valid && seen_estop |-> result.machine_state == MS_ESTOPPED)
    else $error("left estopped state");

  // Pushed kind only with the push pulse
  a_push_kind: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.push_pause_pulse |-> result.pushed_kind == 2'd0)
    else $error("pushed kind without push pulse");

  // A stalled input item stays put
  a_item_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_stall |=> item_valid && $stable(item))
    else $error("stalled input item changed");

endmodule

bind machine_run_hold_supervisor mrhs_checker u_mrhs_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .item         (item),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
